// ===== hdl/sat_pkg.sv =====
// Shared constants and the arctangent table for the screen angle block.
package sat_pkg;

   localparam int VEC_WIDTH         = 16;  // width of each vector component field
   localparam int ANGLE_TURNS_WIDTH = 16;  // width of the result field
   localparam int GUARD_BITS        = 24;  // fraction bits under the coordinates
   localparam int TABLE_LEN         = 24;  // entries of the arctangent table
   localparam int ACC_WIDTH         = 34;  // signed angle accumulator, 2^32 per turn

   localparam int CORDIC_STEPS_DEFAULT = 16;
   localparam int COORD_WIDTH_DEFAULT  = 16;
   localparam int ANGLE_BITS_DEFAULT   = 16;

   // atan(2^-i) / (2 pi) * 2^32, rounded to nearest
   localparam logic [31:0] ATAN_TABLE [TABLE_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

endpackage

// ===== hdl/sat_if.sv =====
// Valid/ready channel interfaces for the vector requests and angle responses.
interface sat_req_if
   import sat_pkg::*;
   ();
   logic                        valid;
   logic                        ready;
   logic signed [VEC_WIDTH-1:0] vec_x;
   logic signed [VEC_WIDTH-1:0] vec_y;

   modport source (output valid, output vec_x, output vec_y, input ready);
   modport sink   (input valid, input vec_x, input vec_y, output ready);
endinterface

interface sat_rsp_if
   import sat_pkg::*;
   ();
   logic                         valid;
   logic                         ready;
   logic [ANGLE_TURNS_WIDTH-1:0] angle_turns;

   modport source (output valid, output angle_turns, input ready);
   modport sink   (input valid, input angle_turns, output ready);
endinterface

// ===== hdl/screen_angle_atan2.sv =====
// Screen angle block: direction of a screen-space vector as a binary angle.
//
// Usage notes
//  - req_chan carries one vector (vec_x, vec_y), y pointing down the screen.
//    A transfer happens on a rising clock edge with valid and ready both high.
//  - rsp_chan returns one angle_turns per vector, in request order, as a
//    fraction of a full turn counted anticlockwise (2^ANGLE_BITS per turn).
//  - Stages: the input stage loads on the transfer edge, then one stage per
//    CORDIC rotation, then one rounding/quadrant stage that also serves as
//    the output register.
//  - Throughput: one vector per cycle while the receiver does not stall;
//    each rotation has its own stage.
//  - Each stage holds while the stage after it is full and stalled, so a
//    stalled receiver first closes up bubbles and only then deasserts
//    req_chan.ready. Nothing is dropped or duplicated.
//  - Reset (synchronous, active high) empties the pipeline; data registers
//    are not cleared.
//  - x == 0 gives a quarter turn for y < 0 and three quarters otherwise,
//    including the origin.
module screen_angle_atan2
   import sat_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT,
   parameter int COORD_WIDTH  = COORD_WIDTH_DEFAULT,
   parameter int ANGLE_BITS   = ANGLE_BITS_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   sat_req_if.sink  req_chan,
   sat_rsp_if.source rsp_chan
);

   // datapath width: magnitude * sqrt(2) * CORDIC gain stays below 2^(CW+26)
   localparam int DW = COORD_WIDTH + GUARD_BITS + 3;
   localparam int LAST = CORDIC_STEPS;           // stage holding the final rotation
   localparam int OUT  = CORDIC_STEPS + 1;       // output stage

   localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
   localparam logic [ANGLE_BITS-1:0] HALF_TURN    = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
   localparam logic [ANGLE_BITS-1:0] THREE_QUARTER_TURN = QUARTER_TURN + HALF_TURN;
   localparam logic [ACC_WIDTH-1:0]  ROUND_HALF = ACC_WIDTH'(1) << (31 - ANGLE_BITS);

   // signs of the input, carried alongside the rotations for the quadrant fold
   typedef struct packed {
      logic x_neg;
      logic x_zero;
      logic y_neg;
      logic y_pos;
   } quad_type;

   // ---------------------------------------------------------------------
   // Pipeline flow control: a stage may load when empty or when it moves on.
   // ---------------------------------------------------------------------
   logic [OUT:0]   valid_ff;
   logic [OUT+1:0] stage_ready;

   always_comb begin
      stage_ready[OUT+1] = rsp_chan.ready;
      for (int s = OUT; s >= 0; s--) begin
         stage_ready[s] = !valid_ff[s] || stage_ready[s+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_ready[0]) begin
            valid_ff[0] <= req_chan.valid;
         end
         for (int s = 1; s <= OUT; s++) begin
            if (stage_ready[s]) begin
               valid_ff[s] <= valid_ff[s-1];
            end
         end
      end
   end

   assign req_chan.ready = stage_ready[0];

   // ---------------------------------------------------------------------
   // Input stage: narrow to COORD_WIDTH, take magnitudes, note the quadrant.
   // ---------------------------------------------------------------------
   logic signed [COORD_WIDTH-1:0] x_cw;
   logic signed [COORD_WIDTH-1:0] y_cw;
   logic        [COORD_WIDTH:0]   ax;
   logic        [COORD_WIDTH:0]   ay;
   logic signed [DW-1:0]          cx_in0;
   logic signed [DW-1:0]          cy_in0;
   quad_type                      quad_in0;

   always_comb begin
      // low COORD_WIDTH bits, sign taken from bit COORD_WIDTH-1
      x_cw = signed'(COORD_WIDTH'(req_chan.vec_x[VEC_WIDTH-1:0]));
      y_cw = signed'(COORD_WIDTH'(req_chan.vec_y[VEC_WIDTH-1:0]));
      ax   = x_cw[COORD_WIDTH-1] ? (COORD_WIDTH+1)'(-(COORD_WIDTH+1)'(x_cw))
                                 : (COORD_WIDTH+1)'(x_cw);
      ay   = y_cw[COORD_WIDTH-1] ? (COORD_WIDTH+1)'(-(COORD_WIDTH+1)'(y_cw))
                                 : (COORD_WIDTH+1)'(y_cw);
      cx_in0 = signed'({2'b00, ax, {GUARD_BITS{1'b0}}});
      cy_in0 = signed'({2'b00, ay, {GUARD_BITS{1'b0}}});
      quad_in0.x_neg  = x_cw[COORD_WIDTH-1];
      quad_in0.x_zero = (x_cw == '0);
      quad_in0.y_neg  = y_cw[COORD_WIDTH-1];
      quad_in0.y_pos  = !y_cw[COORD_WIDTH-1] && (y_cw != '0);
   end

   // ---------------------------------------------------------------------
   // CORDIC vectoring: stage s+1 holds the result of rotation s.
   // ---------------------------------------------------------------------
   logic signed [DW-1:0]        cx_ff   [0:LAST];
   logic signed [DW-1:0]        cy_ff   [0:LAST];
   logic signed [ACC_WIDTH-1:0] z_ff    [0:LAST];
   quad_type                    quad_ff [0:LAST];

   logic signed [DW-1:0]        cx_in   [1:LAST];
   logic signed [DW-1:0]        cy_in   [1:LAST];
   logic signed [ACC_WIDTH-1:0] z_in    [1:LAST];

   always_comb begin
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (!cy_ff[i][DW-1] && (cy_ff[i] != '0)) begin
            // residual above the axis: rotate clockwise
            cx_in[i+1] = cx_ff[i] + (cy_ff[i] >>> i);
            cy_in[i+1] = cy_ff[i] - (cx_ff[i] >>> i);
            z_in[i+1]  = z_ff[i] + signed'(ACC_WIDTH'(ATAN_TABLE[i]));
         end else if (cy_ff[i][DW-1]) begin
            cx_in[i+1] = cx_ff[i] - (cy_ff[i] >>> i);
            cy_in[i+1] = cy_ff[i] + (cx_ff[i] >>> i);
            z_in[i+1]  = z_ff[i] - signed'(ACC_WIDTH'(ATAN_TABLE[i]));
         end else begin
            // exact zero residual: hold
            cx_in[i+1] = cx_ff[i];
            cy_in[i+1] = cy_ff[i];
            z_in[i+1]  = z_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         cx_ff[0]   <= cx_in0;
         cy_ff[0]   <= cy_in0;
         z_ff[0]    <= '0;
         quad_ff[0] <= quad_in0;
      end
      for (int s = 1; s <= LAST; s++) begin
         if (stage_ready[s]) begin
            cx_ff[s]   <= cx_in[s];
            cy_ff[s]   <= cy_in[s];
            z_ff[s]    <= z_in[s];
            quad_ff[s] <= quad_ff[s-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Output stage: clamp, round to ANGLE_BITS, fold into the full turn.
   // ---------------------------------------------------------------------
   logic [ACC_WIDTH-1:0]         z_clamp;
   logic [ACC_WIDTH-1:0]         z_round;
   logic [ANGLE_BITS-1:0]        first_quad;
   logic [ANGLE_BITS-1:0]        angle_fold;
   logic [ANGLE_TURNS_WIDTH-1:0] angle_turns_in;
   logic [ANGLE_TURNS_WIDTH-1:0] angle_turns_ff;

   always_comb begin
      z_clamp    = z_ff[LAST][ACC_WIDTH-1] ? '0 : unsigned'(z_ff[LAST]);
      z_round    = z_clamp + ROUND_HALF;
      first_quad = z_round[31 -: ANGLE_BITS];

      if (quad_ff[LAST].x_zero) begin
         angle_fold = quad_ff[LAST].y_neg ? QUARTER_TURN : THREE_QUARTER_TURN;
      end else if (quad_ff[LAST].x_neg && quad_ff[LAST].y_neg) begin
         angle_fold = HALF_TURN - first_quad;
      end else if (quad_ff[LAST].x_neg) begin
         angle_fold = HALF_TURN + first_quad;
      end else if (quad_ff[LAST].y_pos) begin
         angle_fold = '0 - first_quad;          // full turn minus angle
      end else begin
         angle_fold = first_quad;
      end

      angle_turns_in = ANGLE_TURNS_WIDTH'(angle_fold);
   end

   always_ff @(posedge clock) begin
      if (stage_ready[OUT]) begin
         angle_turns_ff <= angle_turns_in;
      end
   end

   assign rsp_chan.valid       = valid_ff[OUT];
   assign rsp_chan.angle_turns = angle_turns_ff;

endmodule

// ===== hdl/sat_checker.sv =====
// Port-level checks on the screen angle block, bound to its top level.
module sat_checker
   import sat_pkg::*;
(
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [ANGLE_TURNS_WIDTH-1:0] rsp_angle_turns
);

   // pipeline is empty straight after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // an empty or draining output never blocks new requests
   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("request refused although output is free");

   // a stalled response stays offered
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response withdrawn while stalled");

   // a stalled response keeps its angle
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_angle_turns))
      else $error("response angle changed while stalled");

endmodule

bind screen_angle_atan2 sat_checker u_sat_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_angle_turns (rsp_chan.angle_turns)
);

// ===== tb/screen_angle_atan2_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for screen_angle_atan2: directed table, random vectors, CORDIC predictor.
module screen_angle_atan2_tb;
   import sat_pkg::*;

   // Block configuration under test; the predictor follows the same values.
   localparam int CORDIC_STEPS = CORDIC_STEPS_DEFAULT;
   localparam int COORD_WIDTH  = COORD_WIDTH_DEFAULT;
   localparam int ANGLE_BITS   = ANGLE_BITS_DEFAULT;

   // Request transfer to response valid: through the input, rotation and output stages.
   localparam int PIPE_LATENCY   = CORDIC_STEPS + 1;
   localparam int DRAIN_CYCLES   = 2 * PIPE_LATENCY + 8;
   localparam int RANDOM_VECTORS = 1150;
   // Cycles without any transfer on either channel before the run is abandoned.
   // Worst honest stretch is a sender gap plus the pipe latency plus a full receiver stall.
   localparam int WATCHDOG_LIMIT = 2000;

   typedef logic signed [VEC_WIDTH-1:0]   coord_type;
   typedef logic [ANGLE_TURNS_WIDTH-1:0]  angle_type;

   // One row of the directed table. Where typed is set the angle is written
   // in by hand; otherwise the predictor supplies it.
   typedef struct packed {
      coord_type vx;
      coord_type vy;
      logic      typed;
      angle_type angle;
   } vector_row_type;

   localparam int DIRECTED_ROWS = 24;
   localparam vector_row_type DIRECTED [DIRECTED_ROWS] = '{
      // origin and vertical vectors: quarter turn for y < 0, three quarters otherwise
      '{16'sd0,      16'sd0,      1'b1, 16'd49152},
      '{16'sd0,      -16'sd1,     1'b1, 16'd16384},
      '{16'sd0,      16'sd1,      1'b1, 16'd49152},
      '{16'sd0,      -16'sd32768, 1'b1, 16'd16384},
      '{16'sd0,      16'sd32767,  1'b1, 16'd49152},
      // horizontal vectors: zero residual from the start
      '{16'sd1,      16'sd0,      1'b1, 16'd0},
      '{16'sd32767,  16'sd0,      1'b1, 16'd0},
      '{-16'sd1,     16'sd0,      1'b1, 16'd32768},
      '{-16'sd32768, 16'sd0,      1'b1, 16'd32768},
      // exact diagonals: residual clears after the first rotation, eighth turn
      '{16'sd1,      16'sd1,      1'b1, 16'd57344},
      '{-16'sd1,     -16'sd1,     1'b1, 16'd24576},
      '{-16'sd1,     16'sd1,      1'b1, 16'd40960},
      '{16'sd1,      -16'sd1,     1'b1, 16'd8192},
      '{16'sd32767,  16'sd32767,  1'b1, 16'd57344},
      '{-16'sd32768, -16'sd32768, 1'b1, 16'd24576},
      // near the axes: tiny downward angle may wrap to zero
      '{16'sd32767,  16'sd1,      1'b0, 16'd0},
      '{16'sd32767,  -16'sd1,     1'b0, 16'd0},
      '{-16'sd32768, -16'sd1,     1'b0, 16'd0},
      '{-16'sd32768, 16'sd1,      1'b0, 16'd0},
      '{16'sd1,      -16'sd32768, 1'b0, 16'd0},
      '{16'sd1,      16'sd32767,  1'b0, 16'd0},
      // extremes off the diagonal and an ordinary vector
      '{-16'sd32768, 16'sd32767,  1'b0, 16'd0},
      '{16'sd32767,  -16'sd32768, 1'b0, 16'd0},
      '{16'sd3,      -16'sd4,     1'b0, 16'd0}
   };

   localparam coord_type CORNER_VALUES [6] = '{
      -16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767
   };

   logic clock;
   logic reset;

   sat_req_if req_chan ();
   sat_rsp_if rsp_chan ();

   screen_angle_atan2 #(
      .CORDIC_STEPS (CORDIC_STEPS),
      .COORD_WIDTH  (COORD_WIDTH),
      .ANGLE_BITS   (ANGLE_BITS)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   angle_type pending_angles [$];   // angles owed by the block, oldest first
   int        fail_count = 0;
   int        quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Direction of (vx, vy): CORDIC vectoring on |x|, |y| with guard bits,
   // half-up rounding to ANGLE_BITS, then quadrant folding on the signs.
   function automatic angle_type angle_of_vector(input coord_type vx, input coord_type vy);
      longint          sx;
      longint          sy;
      longint          cx;
      longint          cy;
      longint          dx;
      longint          dy;
      longint          z;
      longint unsigned full;
      longint unsigned half;
      longint unsigned quarter;
      longint unsigned a;
      longint unsigned r;
      sx      = vx;
      sy      = vy;
      full    = 64'd1 << ANGLE_BITS;
      half    = full >> 1;
      quarter = full >> 2;
      if (sx != 0) begin
         cx = (sx < 0 ? -sx : sx) <<< GUARD_BITS;
         cy = (sy < 0 ? -sy : sy) <<< GUARD_BITS;
         z  = 0;
         for (int i = 0; i < CORDIC_STEPS && i < TABLE_LEN; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            // a residual of exactly zero holds for the remaining steps
            if (cy > 0) begin
               cx += dx;
               cy -= dy;
               z  += $signed({32'd0, ATAN_TABLE[i]});
            end else if (cy < 0) begin
               cx -= dx;
               cy += dy;
               z  -= $signed({32'd0, ATAN_TABLE[i]});
            end
         end
         if (z < 0)
            z = 0;
         a = ($unsigned(z) + (64'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
      end else begin
         a = (sy < 0) ? quarter : 3 * quarter;
      end
      if (sx < 0 && sy < 0)
         r = half - a;
      else if (sx < 0)
         r = a + half;
      else if (sx > 0 && sy > 0)
         r = full - a;
      else
         r = a;
      r = r & (full - 1);
      return angle_type'(r);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      fail_count++;
   endtask

   // Random vector drawn from a mix: full range, small magnitudes, the axes,
   // diagonals, near-axis slivers and corner values.
   task automatic random_vector(output coord_type vx, output coord_type vy);
      int        kind;
      coord_type m;
      kind = $urandom_range(0, 99);
      m    = coord_type'($urandom);
      if (kind < 35) begin
         vx = coord_type'($urandom);
         vy = coord_type'($urandom);
      end else if (kind < 55) begin
         vx = coord_type'($urandom_range(0, 600)) - 16'sd300;
         vy = coord_type'($urandom_range(0, 600)) - 16'sd300;
      end else if (kind < 63) begin
         vx = 16'sd0;
         vy = $urandom_range(0, 1) ? m : coord_type'($urandom_range(0, 8)) - 16'sd4;
      end else if (kind < 71) begin
         vx = $urandom_range(0, 1) ? m : coord_type'($urandom_range(0, 8)) - 16'sd4;
         vy = 16'sd0;
      end else if (kind < 82) begin
         vx = m;
         vy = $urandom_range(0, 1) ? m : -m;
      end else if (kind < 92) begin
         vx = m;
         vy = coord_type'($urandom_range(0, 8)) - 16'sd4;
         if ($urandom_range(0, 1)) begin
            vy = m;
            vx = coord_type'($urandom_range(0, 8)) - 16'sd4;
         end
      end else begin
         vx = CORNER_VALUES[$urandom_range(0, 5)];
         vy = CORNER_VALUES[$urandom_range(0, 5)];
      end
   endtask

   // Sender side. valid stays high across back-to-back transfers within a
   // burst; each call makes a single assignment per signal in its time step.
   task automatic send_vector(input coord_type vx, input coord_type vy,
                              input logic typed, input angle_type typed_angle);
      req_chan.valid <= 1'b1;
      req_chan.vec_x <= vx;
      req_chan.vec_y <= vy;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      pending_angles.push_back(typed ? typed_angle : angle_of_vector(vx, vy));
   endtask

   // Gap between bursts; the payload carries noise while valid is low.
   task automatic sender_gap(input int cycles);
      req_chan.valid <= 1'b0;
      repeat (cycles) begin
         req_chan.vec_x <= coord_type'($urandom);
         req_chan.vec_y <= coord_type'($urandom);
         @(posedge clock);
      end
   endtask

   // Main sequence: reset, directed table, random vectors, drain, verdict.
   initial begin
      int        burst_left;
      coord_type vx;
      coord_type vy;
      burst_left     = 0;
      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.vec_x <= '0;
      req_chan.vec_y <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int n = 0; n < DIRECTED_ROWS + RANDOM_VECTORS; n++) begin
         if (burst_left == 0) begin
            // mostly real gaps, now and then a burst boundary with no gap
            if ($urandom_range(0, 3) != 0)
               sender_gap($urandom_range(1, 12));
            burst_left = $urandom_range(1, 40);
         end
         burst_left--;
         if (n < DIRECTED_ROWS) begin
            send_vector(DIRECTED[n].vx, DIRECTED[n].vy, DIRECTED[n].typed,
                        DIRECTED[n].angle);
         end else begin
            random_vector(vx, vy);
            send_vector(vx, vy, 1'b0, '0);
         end
      end
      req_chan.valid <= 1'b0;

      // wait for every owed angle; the watchdog catches a block that loses one
      while (pending_angles.size() != 0)
         @(posedge clock);
      // let any stray response surface before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Receiver side: ready follows a 16-bit stall pattern that rotates each
   // cycle and is redrawn after a random span. One mode never stalls.
   initial begin
      logic [15:0] stall_pattern;
      int          span_left;
      stall_pattern  = 16'hFFFF;
      span_left      = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (span_left == 0) begin
            case ($urandom_range(0, 3))
               0: begin
                  stall_pattern = 16'hFFFF;
               end
               1: begin
                  stall_pattern = 16'($urandom);
               end
               2: begin
                  stall_pattern = 16'($urandom) & 16'($urandom);
               end
               default: begin
                  stall_pattern = 16'($urandom) | 16'($urandom);
               end
            endcase
            if (stall_pattern == 16'h0000)
               stall_pattern = 16'h0001;
            span_left = $urandom_range(16, 200);
         end
         span_left--;
         rsp_chan.ready <= stall_pattern[0];
         stall_pattern  = {stall_pattern[0], stall_pattern[15:1]};
      end
   end

   // Response checker: each transfer against the oldest owed angle.
   always @(posedge clock) begin
      angle_type owed;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_angles.size() == 0) begin
            report_mismatch($sformatf("unexpected response angle_turns=%0d",
                                      rsp_chan.angle_turns));
         end else begin
            owed = pending_angles.pop_front();
            if (rsp_chan.angle_turns !== owed)
               report_mismatch($sformatf("angle_turns=%0d, predicted %0d",
                                         rsp_chan.angle_turns, owed));
         end
      end
   end

   // Watchdog: counts cycles with no transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR @%0t: no transfer for %0d cycles, %0d angles owed",
                     $time, quiet_cycles, pending_angles.size());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

endmodule

// ===== files.f =====
hdl/sat_pkg.sv
hdl/sat_if.sv
hdl/screen_angle_atan2.sv
hdl/sat_checker.sv
tb/screen_angle_atan2_tb.sv
